FILE: rtl/bsr_pkg.sv
`default_nettype none
package bsr_pkg;
  localparam int unsigned Window   = 64;
  localparam int unsigned MaxFlush = 64;
  localparam int unsigned SlotW    = $clog2(Window);
  localparam int unsigned CntW     = 7;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);

  // One accepted beat as packed by the front part.
  typedef struct packed {
    logic [31:0]     pos;
    logic [7:0]      value;
    logic            has_byte;
    logic            seg_last;
    logic            eof;
    logic [CntW-1:0] space;
  } cmd_t;
endpackage
`default_nettype wire

FILE: rtl/bsr_if.sv
`default_nettype none
interface bsr_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] byte_index;
  logic [7:0]  byte_value;
  logic        has_byte;
  logic        seg_last;
  logic        eof;
  logic [6:0]  out_space;
  modport source (output valid, byte_index, byte_value, has_byte, seg_last, eof, out_space,
                  input ready);
  modport sink (input valid, byte_index, byte_value, has_byte, seg_last, eof, out_space,
                output ready);
endinterface

interface bsr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_last;
  logic [6:0] unassembled;
  logic       stream_ended;
  modport source (output valid, out_byte, byte_valid, run_last, unassembled, stream_ended,
                  input ready);
  modport sink (input valid, out_byte, byte_valid, run_last, unassembled, stream_ended,
                output ready);
endinterface
`default_nettype wire

FILE: rtl/bsr_ram.sv
`default_nettype none
module bsr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]              rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Single write port, registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: rtl/bsr_queue.sv
`default_nettype none
module bsr_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire bsr_pkg::cmd_t data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output bsr_pkg::cmd_t      data_o,
  output logic               empty_o
);
  import bsr_pkg::*;

  cmd_t             slot_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QPtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (QPtrW+1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = slot_q[rd_q];

  // Small register queue between the front and the back.
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + {{QPtrW{1'b0}}, push_i} - {{QPtrW{1'b0}}, pop_i};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni) full_o |-> !push_i)
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni) empty_o |-> !pop_i)
    else $error("queue underflow");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count slip");
`endif
endmodule
`default_nettype wire

FILE: rtl/bsr_back.sv
`default_nettype none
module bsr_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire bsr_pkg::cmd_t cmd_i,
  input  wire logic          cmd_empty_i,
  output logic               cmd_pop_o,
  bsr_out_if.source          out
);
  import bsr_pkg::*;

  typedef enum logic [2:0] {
    StCmd  = 3'b001,
    StScan = 3'b010,
    StEmit = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [Window-1:0] valid_q;
  logic [31:0]       wpos_q;
  logic [CntW-1:0]   pend_q;
  logic              end_known_q;
  logic [32:0]       end_pos_q;
  logic [CntW-1:0]   limit_q, run_q, emit_q;
  logic              ram_we;
  logic [SlotW-1:0]  ram_waddr, ram_raddr;
  logic [7:0]        ram_rdata;
  logic              ob_valid_q, ob_bvalid_q, ob_last_q, ob_ended_q;
  logic [7:0]        ob_byte_q;
  logic [CntW-1:0]   ob_unas_q;
  logic              ob_free, rd_pending_q;
  logic [31:0]       offset;
  logic              in_win;
  logic [SlotW-1:0]  scan_slot, cmd_slot;
  logic              ended_now;

  assign offset    = cmd_i.pos - wpos_q;
  assign in_win    = cmd_i.has_byte && (offset < 32'(Window));
  assign cmd_slot  = cmd_i.pos[SlotW-1:0];
  assign scan_slot = SlotW'(wpos_q + 32'(run_q));
  assign ram_we    = (state_q == StCmd) && !cmd_empty_i && in_win;
  assign ram_waddr = cmd_slot;
  // While a read is waiting for the output register, keep addressing the slot just read.
  assign ram_raddr = SlotW'(wpos_q + 32'(emit_q) - {31'd0, rd_pending_q});
  assign ob_free   = !ob_valid_q || out.ready;
  assign cmd_pop_o = (state_q == StCmd) && !cmd_empty_i;
  assign ended_now = end_known_q && (end_pos_q == {1'b0, wpos_q + 32'(run_q)});

  bsr_ram #(.Width(8), .Depth(Window)) u_store (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(cmd_i.value),
    .raddr_i(ram_raddr), .rdata_o(ram_rdata)
  );

  // Write a byte, then on a segment end scan the valid run and drain it a beat at a time.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StCmd:  if (cmd_pop_o && cmd_i.seg_last) state_d = StScan;
      StScan: if (!(run_q < limit_q && valid_q[scan_slot])) state_d = StEmit;
      StEmit: if (ob_free && !rd_pending_q && (emit_q == run_q)) state_d = StCmd;
      default: state_d = StCmd;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StCmd;
      valid_q      <= '0;
      wpos_q       <= '0;
      pend_q       <= '0;
      end_known_q  <= 1'b0;
      end_pos_q    <= '0;
      limit_q      <= '0;
      run_q        <= '0;
      emit_q       <= '0;
      ob_valid_q   <= 1'b0;
      rd_pending_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ob_valid_q && out.ready) ob_valid_q <= 1'b0;
      case (state_q)
        StCmd: if (cmd_pop_o) begin
          if (in_win && !valid_q[cmd_slot]) begin
            valid_q[cmd_slot] <= 1'b1;
            pend_q            <= pend_q + 1'b1;
          end
          if (cmd_i.seg_last) begin
            limit_q <= (cmd_i.space > CntW'(MaxFlush)) ? CntW'(MaxFlush) : cmd_i.space;
            run_q   <= '0;
            emit_q  <= '0;
            if (cmd_i.eof) begin
              end_known_q <= 1'b1;
              end_pos_q   <= {1'b0, cmd_i.pos} + {32'd0, cmd_i.has_byte};
            end
          end
        end
        StScan: if (run_q < limit_q && valid_q[scan_slot]) begin
          run_q <= run_q + 1'b1;
        end else begin
          // Status fields for this segment are fixed here.
          pend_q     <= pend_q - run_q;
          ob_unas_q  <= pend_q - run_q;
          ob_ended_q <= ended_now;
          if (run_q == '0) begin
            ob_valid_q  <= 1'b1;
            ob_byte_q   <= 8'd0;
            ob_bvalid_q <= 1'b0;
            ob_last_q   <= 1'b1;
          end
        end
        StEmit: begin
          if (rd_pending_q && ob_free) begin
            ob_valid_q   <= 1'b1;
            ob_byte_q    <= ram_rdata;
            ob_bvalid_q  <= 1'b1;
            ob_last_q    <= (emit_q == run_q);
            rd_pending_q <= 1'b0;
          end else if (!rd_pending_q && emit_q != run_q) begin
            valid_q[ram_raddr] <= 1'b0;
            emit_q             <= emit_q + 1'b1;
            rd_pending_q       <= 1'b1;
          end
          if (ob_free && !rd_pending_q && emit_q == run_q) wpos_q <= wpos_q + 32'(run_q);
        end
        default: ;
      endcase
    end
  end

  assign out.valid        = ob_valid_q;
  assign out.out_byte     = ob_byte_q;
  assign out.byte_valid   = ob_bvalid_q;
  assign out.run_last     = ob_last_q;
  assign out.unassembled  = ob_unas_q;
  assign out.stream_ended = ob_ended_q;

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) emit_q <= run_q)
    else $error("emitted past run");
  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
      run_q <= CntW'(MaxFlush))
    else $error("run beyond flush limit");
`endif
endmodule
`default_nettype wire

FILE: rtl/byte_stream_reassembler.sv
// Channel  Direction  Beat contents
// in_ch    sink       byte_index, byte_value, has_byte, seg_last, eof, out_space
// out_ch   source     out_byte, byte_valid, run_last, unassembled, stream_ended
// A beat enters the queue when the queue is not full; the back part retires a beat that is not a
// segment end from StCmd. A segment end scans the valid map in StScan, then reads each
// run byte through the registered store read port in StEmit before returning to StCmd.
// Reset clears the valid map, positions and counts at once; no clearing pass.
// The input stalls only when the four-entry queue is full; the output register holds.
`default_nettype none
module byte_stream_reassembler (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  bsr_in_if.sink    in_ch,
  bsr_out_if.source out_ch
);
  import bsr_pkg::*;

  cmd_t q_in, q_out;
  logic full, empty, pop;

  // Front part: pack the beat into a command.
  assign q_in.pos      = in_ch.byte_index;
  assign q_in.value    = in_ch.byte_value;
  assign q_in.has_byte = in_ch.has_byte;
  assign q_in.seg_last = in_ch.seg_last;
  assign q_in.eof      = in_ch.eof;
  assign q_in.space    = in_ch.out_space;
  assign in_ch.ready   = !full;

  bsr_queue u_queue (
    .clk_i, .rst_ni, .push_i(in_ch.valid && !full), .data_i(q_in), .full_o(full),
    .pop_i(pop), .data_o(q_out), .empty_o(empty)
  );

  bsr_back u_back (
    .clk_i, .rst_ni, .cmd_i(q_out), .cmd_empty_i(empty), .cmd_pop_o(pop), .out(out_ch)
  );
endmodule
`default_nettype wire

FILE: dv/bsr_tb_if.sv
`default_nettype none
// Separate copies of the channel interfaces are not needed; the RTL interfaces are used.
// This file holds the beat types and the scoreboard used by the testbench.
package bsr_tb_pkg;
  // One input beat as the stimulus sees it.
  typedef struct {
    logic [31:0] byte_index;
    logic [7:0]  byte_value;
    logic        has_byte;
    logic        seg_last;
    logic        eof;
    logic [6:0]  out_space;
  } seg_beat_t;

  // One result beat as the block emits it.
  typedef struct {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic [6:0] unassembled;
    logic       stream_ended;
  } run_beat_t;

  // Tracks the reassembly window and holds the run bytes still to arrive.
  class reassembly_scoreboard;
    logic [7:0]  win_data[64];
    bit          win_mark[64];
    logic [31:0] wr_pos;
    int unsigned held_count;
    bit          end_seen;
    logic [32:0] end_pos;
    run_beat_t   pending_runs[$];
    int          errors;
    int          runs_checked;

    function new();
      foreach (win_mark[i]) win_mark[i] = 0;
      wr_pos = '0;
      held_count = 0;
      end_seen = 0;
      end_pos = '0;
      errors = 0;
      runs_checked = 0;
    endfunction

    // Apply one accepted input beat and queue the results it causes.
    function void note_beat(seg_beat_t b);
      logic [31:0] offset;
      int unsigned cap, run_len, k;
      logic [7:0] run_bytes[64];
      bit finished;
      run_beat_t r;
      if (b.has_byte) begin
        offset = b.byte_index - wr_pos;
        if (offset < 64) begin
          win_data[b.byte_index[5:0]] = b.byte_value;
          if (!win_mark[b.byte_index[5:0]]) begin
            win_mark[b.byte_index[5:0]] = 1;
            held_count++;
          end
        end
      end
      if (!b.seg_last) return;
      cap = (b.out_space > 64) ? 64 : b.out_space;
      run_len = 0;
      while (run_len < cap && win_mark[6'(wr_pos + run_len)]) begin
        run_bytes[run_len] = win_data[6'(wr_pos + run_len)];
        run_len++;
      end
      for (k = 0; k < run_len; k++) win_mark[6'(wr_pos + k)] = 0;
      wr_pos += run_len;
      held_count -= run_len;
      if (b.eof) begin
        end_seen = 1;
        end_pos = {1'b0, b.byte_index} + (b.has_byte ? 33'd1 : 33'd0);
      end
      finished = end_seen && (end_pos == {1'b0, wr_pos});
      r.unassembled = (held_count > 127) ? 7'd127 : 7'(held_count);
      r.stream_ended = finished;
      if (run_len == 0) begin
        r.out_byte = '0;
        r.byte_valid = 0;
        r.run_last = 1;
        pending_runs.push_back(r);
      end else begin
        for (k = 0; k < run_len; k++) begin
          r.out_byte = run_bytes[k];
          r.byte_valid = 1;
          r.run_last = (k + 1 == run_len);
          pending_runs.push_back(r);
        end
      end
    endfunction

    // Compare one accepted result beat with the oldest expectation.
    function void check_run(run_beat_t got);
      run_beat_t exp;
      runs_checked++;
      if (pending_runs.size() == 0) begin
        $display("%0t: unexpected result beat byte=%0h", $time, got.out_byte);
        errors++;
        return;
      end
      exp = pending_runs.pop_front();
      if (got.out_byte !== exp.out_byte) begin
        $display("%0t: out_byte expected %0h actual %0h", $time, exp.out_byte, got.out_byte);
        errors++;
      end
      if (got.byte_valid !== exp.byte_valid) begin
        $display("%0t: byte_valid expected %0b actual %0b", $time, exp.byte_valid,
                 got.byte_valid);
        errors++;
      end
      if (got.run_last !== exp.run_last) begin
        $display("%0t: run_last expected %0b actual %0b", $time, exp.run_last, got.run_last);
        errors++;
      end
      if (got.unassembled !== exp.unassembled) begin
        $display("%0t: unassembled expected %0d actual %0d", $time, exp.unassembled,
                 got.unassembled);
        errors++;
      end
      if (got.stream_ended !== exp.stream_ended) begin
        $display("%0t: stream_ended expected %0b actual %0b", $time, exp.stream_ended,
                 got.stream_ended);
        errors++;
      end
    endfunction
  endclass
endpackage
`default_nettype wire

FILE: dv/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bsr_tb_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  bsr_in_if  in_ch();
  bsr_out_if out_ch();

  byte_stream_reassembler dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_ch(in_ch),
                               .out_ch(out_ch));

  reassembly_scoreboard sb = new();
  seg_beat_t beats[$];
  int unsigned beats_sent = 0;
  int unsigned segments_sent = 0;
  int unsigned idle_cycles = 0;
  bit hold_off = 0;
  logic [31:0] base_pos = 0;

  always #1 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 0;
    in_ch.byte_index = '0;
    in_ch.byte_value = '0;
    in_ch.has_byte = 0;
    in_ch.seg_last = 0;
    in_ch.eof = 0;
    in_ch.out_space = '0;
    out_ch.ready = 0;
  end

  // Add one beat to the stimulus list.
  task automatic add_beat(logic [31:0] idx, logic [7:0] val, bit hb, bit last, bit e,
                          logic [6:0] space);
    seg_beat_t b;
    b.byte_index = idx; b.byte_value = val; b.has_byte = hb;
    b.seg_last = last; b.eof = e; b.out_space = space;
    beats.push_back(b);
  endtask

  // A segment of random content at an offset from the current base position.
  task automatic add_segment(int offset, int len, bit e, logic [6:0] space);
    int i;
    for (i = 0; i < len; i++)
      add_beat(base_pos + offset + i, 8'($urandom), 1, i == len - 1, e, space);
    if (len == 0) add_beat(base_pos + offset, 8'($urandom), 0, 1, e, space);
  endtask

  // Drive all queued beats in bursts with random gaps, then drop valid.
  task automatic send_beats();
    seg_beat_t b;
    int burst;
    while (beats.size() > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && beats.size() > 0) begin
        b = beats.pop_front();
        in_ch.valid <= 1;
        in_ch.byte_index <= b.byte_index;
        in_ch.byte_value <= b.byte_value;
        in_ch.has_byte <= b.has_byte;
        in_ch.seg_last <= b.seg_last;
        in_ch.eof <= b.eof;
        in_ch.out_space <= b.out_space;
        @(posedge clk_i);
        while (!in_ch.ready) @(posedge clk_i);
        sb.note_beat(b);
        beats_sent++;
        if (b.seg_last) segments_sent++;
        burst--;
      end
      if (beats.size() > 0 && $urandom_range(0, 3) != 0) begin
        in_ch.valid <= 0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    in_ch.valid <= 0;
    @(posedge clk_i);
  endtask

  // Receiver: a pattern of stalls, with one forced long hold-off.
  always @(posedge clk_i) begin
    if (!rst_ni || hold_off) out_ch.ready <= 0;
    else out_ch.ready <= ($urandom_range(0, 9) < 7);
  end

  // Sample accepted result beats.
  always @(posedge clk_i) begin
    run_beat_t r;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      r.out_byte = out_ch.out_byte;
      r.byte_valid = out_ch.byte_valid;
      r.run_last = out_ch.run_last;
      r.unassembled = out_ch.unassembled;
      r.stream_ended = out_ch.stream_ended;
      sb.check_run(r);
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("byte_stream_reassembler verification failed");
      $finish;
    end
  end

  initial begin
    int i, off, len, drain;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: in-order, out-of-order, overlap, outside window, empty segments.
    add_segment(0, 3, 0, 7'd64);
    add_segment(5, 2, 0, 7'd64);
    add_segment(3, 2, 0, 7'd64);
    add_segment(0, 1, 0, 7'd64);
    add_segment(64 + 7, 1, 0, 7'd64);
    add_segment(10, 0, 0, 7'd0);
    add_beat(7, 8'hff, 1, 0, 0, 7'd0);
    add_beat(7, 8'h00, 1, 1, 0, 7'd0);
    add_beat(8, 8'h5a, 1, 1, 0, 7'd127);
    add_beat(9, 8'ha5, 1, 1, 0, 7'd1);
    add_beat(12, 8'h00, 0, 1, 1, 7'd5);
    add_beat(9, 8'h11, 1, 0, 0, 7'd0);
    add_beat(10, 8'h22, 1, 0, 0, 7'd0);
    add_beat(11, 8'h33, 1, 1, 1, 7'd100);
    send_beats();
    base_pos = sb.wr_pos;

    // Long hold-off so that the block fills and stalls its input.
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk_i);
        hold_off = 0;
      end
      begin
        for (i = 0; i < 8; i++) add_segment(i * 4, 4, 0, 7'd64);
        send_beats();
      end
    join
    base_pos = sb.wr_pos;

    // Random: mostly windowed segments and some far-away noise.
    while (beats_sent < 255) begin
      base_pos = sb.wr_pos;
      case ($urandom_range(0, 9))
        0: add_beat($urandom, 8'($urandom), $urandom_range(0, 1), 1, $urandom_range(0, 1),
                    7'($urandom));
        1: add_segment($urandom_range(0, 70), $urandom_range(0, 3), $urandom_range(0, 1),
                       7'($urandom_range(0, 127)));
        default: begin
          off = $urandom_range(0, 40);
          len = $urandom_range(1, 10);
          add_segment(off, len, ($urandom_range(0, 15) == 0), 7'($urandom_range(0, 70)));
        end
      endcase
      if (beats_sent > 150 && beats_sent < 160 && sb.held_count == 0)
        sb.wr_pos = sb.wr_pos;
      send_beats();
    end

    // Drain remaining results.
    drain = 0;
    while (sb.pending_runs.size() > 0 && drain < 20000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (200) @(posedge clk_i);
    $display("Sent %0d beats in %0d segments, checked %0d result beats.", beats_sent,
             segments_sent, sb.runs_checked);
    if (sb.errors == 0 && sb.pending_runs.size() == 0)
      $display("byte_stream_reassembler verification clean");
    else begin
      if (sb.pending_runs.size() != 0)
        $display("%0t: %0d expected result beats never arrived", $time,
                 sb.pending_runs.size());
      $display("byte_stream_reassembler verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: files.f
rtl/bsr_pkg.sv
rtl/bsr_if.sv
rtl/bsr_ram.sv
rtl/bsr_queue.sv
rtl/bsr_back.sv
rtl/byte_stream_reassembler.sv
dv/bsr_tb_if.sv
dv/testbench.sv
